### rtl/core/pscl_pkg.sv
// ----------------------------------------------------------------------------
// pscl_pkg
// Shared sizes and codes of the per-source connection limit table.
// ----------------------------------------------------------------------------
package pscl_pkg;

  // Table geometry
  localparam int TABLE_DEPTH  = 64;
  localparam int CONN_ID_BITS = 16;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);

  // Field widths of the ports
  localparam int SRC_W     = 32;
  localparam int CONN_W    = 16;
  localparam int CONN_KEEP = (CONN_ID_BITS < CONN_W) ? CONN_ID_BITS : CONN_W;
  localparam int LIMIT_W   = 7;
  localparam int CFG_ADDR_W = 1;
  localparam int OUT_CNT_W = 7;
  localparam int CMP_W     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int COUNT_MAX = (1 << OUT_CNT_W) - 1;

  // Operation codes
  localparam logic OP_OPEN  = 1'b0;
  localparam logic OP_CLOSE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PER_SRC   = 2'd1;
  localparam logic [1:0] ST_TOTAL     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PER_SRC = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_TOTAL   = 1'd1;

  // Register reset values
  localparam logic [LIMIT_W-1:0] MAX_PER_SRC_RST = 7'd8;
  localparam logic [LIMIT_W-1:0] MAX_TOTAL_RST   = 7'd64;

endpackage

### rtl/core/per_source_connection_limiter_unit.sv
// ----------------------------------------------------------------------------
// per_source_connection_limiter_unit
// Connection table with per-source and total limits on open requests.
// ----------------------------------------------------------------------------
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  ------------------------
//  request  in_opcode, in_source_ip, in_conn_id     start & !busy
//  result   out_accepted, out_status, out_*_count   out_valid, one cycle
//  config   cfg_addr, cfg_wdata                     cfg_we, no wait
//
// Each request walks the whole table: one table entry is read from the
// entry memory and checked per cycle, then the decide state decides and
// updates the table. The result strobe rises the cycle busy falls; the
// next request may be taken in that same cycle. The receiver cannot stall.
// Reset clears the valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module per_source_connection_limiter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic [pscl_pkg::SRC_W-1:0]      in_source_ip,
  input  logic [pscl_pkg::CONN_W-1:0]     in_conn_id,
  output logic                            out_valid,
  output logic                            out_accepted,
  output logic [1:0]                      out_status,
  output logic [pscl_pkg::OUT_CNT_W-1:0]  out_source_count,
  output logic [pscl_pkg::OUT_CNT_W-1:0]  out_total_count,
  input  logic                            cfg_we,
  input  logic [pscl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pscl_pkg::LIMIT_W-1:0]    cfg_wdata
);
  import pscl_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE} state_t;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(TABLE_DEPTH - 1);

  state_t                state_r;
  logic [LIMIT_W-1:0]    max_ps_r;
  logic [LIMIT_W-1:0]    max_tot_r;

  // Latched request
  logic                  op_r;
  logic [SRC_W-1:0]      src_r;
  logic [CONN_KEEP-1:0]  conn_r;

  // Scan: issue stage and check stage
  logic [ADDR_W-1:0]     idx_r;
  logic                  issue_r;
  logic                  chk_r;
  logic [ADDR_W-1:0]     chk_idx_r;
  logic                  chk_vld_r;

  // Scan results
  logic [CNT_W-1:0]      sc_r;
  logic [CNT_W-1:0]      tc_r;
  logic                  found_r;
  logic [ADDR_W-1:0]     hit_r;
  logic                  have_free_r;
  logic [ADDR_W-1:0]     free_r;

  // Table storage
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [SRC_W-1:0]       src_mem [TABLE_DEPTH];
  logic [CONN_KEEP-1:0]   conn_mem [TABLE_DEPTH];
  logic [SRC_W-1:0]       src_q_r;
  logic [CONN_KEEP-1:0]   conn_q_r;

  // Decision
  logic                  ins;
  logic                  rem;
  logic                  full;
  logic [CNT_W-1:0]      sc_nxt;
  logic [CNT_W-1:0]      tc_nxt;
  logic [CMP_W-1:0]      sc_ext;
  logic [CMP_W-1:0]      tc_ext;
  logic                  acc_nxt;
  logic [1:0]            status_nxt;
  logic                  src_hit;

  assign busy    = (state_r != S_IDLE);
  assign src_hit = (src_q_r == src_r);

  always_comb begin
    ins  = (op_r == OP_OPEN) && !found_r && have_free_r;
    full = (op_r == OP_OPEN) && !found_r && !have_free_r;
    rem  = (op_r == OP_CLOSE) && found_r;
    sc_nxt = sc_r;
    tc_nxt = tc_r;
    if (ins) begin
      sc_nxt = sc_r + CNT_W'(1);
      tc_nxt = tc_r + CNT_W'(1);
    end else if (rem) begin
      sc_nxt = sc_r - CNT_W'(1);
      tc_nxt = tc_r - CNT_W'(1);
    end
    sc_ext = CMP_W'(sc_nxt);
    tc_ext = CMP_W'(tc_nxt);
    acc_nxt    = 1'b0;
    status_nxt = ST_OK;
    if (op_r == OP_CLOSE) begin
      acc_nxt = found_r;
    end else if (full) begin
      status_nxt = ST_FULL;
    end else if (sc_ext > CMP_W'(max_ps_r)) begin
      status_nxt = ST_PER_SRC;
    end else if (tc_ext > CMP_W'(max_tot_r)) begin
      status_nxt = ST_TOTAL;
    end else begin
      acc_nxt = 1'b1;
    end
  end

  // Entry memories: one read and one write port each
  always_ff @(posedge clk) begin
    if (state_r == S_DECIDE && ins) begin
      src_mem[free_r]  <= src_r;
      conn_mem[free_r] <= conn_r;
    end
    src_q_r  <= src_mem[idx_r];
    conn_q_r <= conn_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_ps_r    <= MAX_PER_SRC_RST;
      max_tot_r   <= MAX_TOTAL_RST;
      valid_r     <= '0;
      issue_r     <= 1'b0;
      chk_r       <= 1'b0;
      out_valid   <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_MAX_PER_SRC: max_ps_r  <= cfg_wdata;
          CFG_MAX_TOTAL:   max_tot_r <= cfg_wdata;
          default:         ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r        <= in_opcode;
            src_r       <= in_source_ip;
            conn_r      <= in_conn_id[CONN_KEEP-1:0];
            idx_r       <= '0;
            issue_r     <= 1'b1;
            chk_r       <= 1'b0;
            sc_r        <= '0;
            tc_r        <= '0;
            found_r     <= 1'b0;
            have_free_r <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Issue: read one entry and its valid bit
          chk_r <= issue_r;
          if (issue_r) begin
            chk_idx_r <= idx_r;
            chk_vld_r <= valid_r[idx_r];
            if (idx_r == LAST_IDX) begin
              issue_r <= 1'b0;
            end else begin
              idx_r <= idx_r + ADDR_W'(1);
            end
          end
          // Check: compare the entry read last cycle
          if (chk_r) begin
            if (chk_vld_r) begin
              tc_r <= tc_r + CNT_W'(1);
              if (src_hit) begin
                sc_r <= sc_r + CNT_W'(1);
              end
              if (!found_r && src_hit && conn_q_r == conn_r) begin
                found_r <= 1'b1;
                hit_r   <= chk_idx_r;
              end
            end else if (!have_free_r) begin
              have_free_r <= 1'b1;
              free_r      <= chk_idx_r;
            end
            if (chk_idx_r == LAST_IDX) begin
              chk_r   <= 1'b0;
              state_r <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (ins) begin
            valid_r[free_r] <= 1'b1;
          end else if (rem) begin
            valid_r[hit_r] <= 1'b0;
          end
          out_valid        <= 1'b1;
          out_accepted     <= acc_nxt;
          out_status       <= status_nxt;
          out_source_count <= (sc_ext > CMP_W'(COUNT_MAX)) ?
                              OUT_CNT_W'(COUNT_MAX) : sc_ext[OUT_CNT_W-1:0];
          out_total_count  <= (tc_ext > CMP_W'(COUNT_MAX)) ?
                              OUT_CNT_W'(COUNT_MAX) : tc_ext[OUT_CNT_W-1:0];
          state_r          <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A result appears only once the walk is over
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // A taken request starts the walk
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // Any refusal code comes with accepted low
  a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> !out_accepted)
    else $error("refused request marked accepted");

  // Per-source count never passes the total
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_source_count <= out_total_count))
    else $error("source count above total count");

endmodule
